### hdl/cba_pkg.sv
package cba_pkg;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int COUNT_W  = 11;
  localparam int INDEX_W  = 10;
  localparam int MARK_W   = 2;
  localparam int FIRST_W  = 10;
  localparam int END_W    = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 16;

  // Operations
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // Bank marks
  localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
  localparam logic [MARK_W-1:0] MARK_USED = 2'd1;
  localparam logic [MARK_W-1:0] MARK_HEAD = 2'd2;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_FIRST = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_END   = 1'd1;

  // Result codes
  localparam logic RC_DONE    = 1'b0;
  localparam logic RC_NO_FIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_WRITE,
    ST_QUERY,
    ST_RESP
  } state_t;

  // Control from the sequencer to the run counter
  typedef struct packed {
    logic clear;
    logic step;
  } run_ctl_t;

endpackage

### hdl/cba_ram.sv
module cba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/cba_run_unit.sv
module cba_run_unit import cba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  run_ctl_t           ctl,
  input  logic               mark_free,
  input  logic [COUNT_W-1:0] need,
  output logic               hit
);

  logic [COUNT_W-1:0] run;
  logic [COUNT_W-1:0] run_next;
  logic [COUNT_W-1:0] run_inc;

  // Count consecutive free banks; a used bank restarts the run
  always_comb begin
    run_inc  = mark_free ? COUNT_W'(run + 1'b1) : '0;
    hit      = ctl.step && (run_inc == need);
    run_next = run;
    if (ctl.clear) begin
      run_next = '0;
    end else if (ctl.step) begin
      run_next = run_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else begin
      run <= run_next;
    end
  end

endmodule

### hdl/contiguous_bank_allocator.sv
// Channel   Dir  Fields (low bit up)                                  Handshake
// s_*       in   opcode[1:0] bank_count[12:2] bank_index[22:13]       tvalid/tready
// m_*       out  start_bank[9:0] result_code[10] bank_mark[12:11]     tvalid/tready
// cfg_*     in   index 0 window_first_bank, 1 window_end_bank         cfg_we only
//
// Allocate: scans the window one bank per cycle through the registered mark RAM
// read port, then marks the run used, head first. Free and opcode 3 go straight
// to the response state, query via ST_QUERY; all then load the output register.
// After rst the mark RAM is swept to free, bank by bank, with s_tready low.
// One transaction at a time; a result waiting in the output register holds the
// sequencer in its response state until m_tready takes it.
module contiguous_bank_allocator import cba_pkg::*; #(
  parameter int STORE_BANKS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // opcode, bank_count, bank_index
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // start_bank, result_code, bank_mark
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(STORE_BANKS);

  state_t state, state_next;

  logic [FIRST_W-1:0]  win_first;
  logic [END_W-1:0]    win_end;
  logic [END_W-1:0]    end_eff;

  logic [OPCODE_W-1:0] op_r, op_next;
  logic [COUNT_W-1:0]  need_r, need_next;
  logic [INDEX_W-1:0]  idx_r, idx_next;

  logic [END_W-1:0]    scan_ptr, scan_ptr_next;
  logic [END_W-1:0]    eval_ptr, eval_ptr_next;
  logic                pend, pend_next;
  logic [END_W-1:0]    start_r, start_next;
  logic [END_W-1:0]    run_end, run_end_next;
  logic [END_W-1:0]    wr_ptr, wr_ptr_next;
  logic [AW-1:0]       clr_ptr, clr_ptr_next;

  logic [INDEX_W-1:0]  res_start, res_start_next;
  logic                res_code, res_code_next;
  logic [MARK_W-1:0]   res_mark, res_mark_next;
  logic                out_load;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [MARK_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [MARK_W-1:0]   ram_rdata;

  run_ctl_t            run_ctl;
  logic                run_hit;

  logic                in_accept;
  logic [OPCODE_W-1:0] in_op;
  logic [COUNT_W-1:0]  in_count;
  logic [INDEX_W-1:0]  in_index;
  logic                in_idx_ok;
  logic                idx_ok;

  assign in_op    = s_tdata[1:0];
  assign in_count = s_tdata[12:2];
  assign in_index = s_tdata[22:13];

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_idx_ok = 32'(in_index) < 32'(STORE_BANKS);
  assign idx_ok    = 32'(idx_r) < 32'(STORE_BANKS);

  // Window end clipped to the store
  assign end_eff = (32'(win_end) > 32'(STORE_BANKS)) ? END_W'(STORE_BANKS) : win_end;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win_first <= '0;
      win_end   <= END_W'(1024);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIN_FIRST: win_first <= cfg_data[FIRST_W-1:0];
        REG_WIN_END:   win_end   <= cfg_data[END_W-1:0];
        default: ;
      endcase
    end
  end

  cba_ram #(
    .WIDTH (MARK_W),
    .DEPTH (STORE_BANKS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cba_run_unit u_run (
    .clk       (clk),
    .rst       (rst),
    .ctl       (run_ctl),
    .mark_free (ram_rdata == MARK_FREE),
    .need      (need_r),
    .hit       (run_hit)
  );

  // Sequencer: next state, datapath updates and mark RAM port control
  always_comb begin
    state_next     = state;
    op_next        = op_r;
    need_next      = need_r;
    idx_next       = idx_r;
    scan_ptr_next  = scan_ptr;
    eval_ptr_next  = eval_ptr;
    pend_next      = pend;
    start_next     = start_r;
    run_end_next   = run_end;
    wr_ptr_next    = wr_ptr;
    clr_ptr_next   = clr_ptr;
    res_start_next = res_start;
    res_code_next  = res_code;
    res_mark_next  = res_mark;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = MARK_FREE;
    ram_raddr      = AW'(in_index);
    run_ctl        = '0;

    case (state)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_ptr;
        clr_ptr_next = AW'(clr_ptr + 1'b1);
        if (32'(clr_ptr) == 32'(STORE_BANKS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          op_next        = in_op;
          need_next      = in_count;
          idx_next       = in_index;
          res_start_next = '0;
          res_code_next  = RC_DONE;
          res_mark_next  = MARK_FREE;
          case (in_op)
            OP_ALLOC: state_next = ST_ALLOC;
            OP_FREE: begin
              ram_we     = in_idx_ok;
              ram_waddr  = AW'(in_index);
              state_next = ST_RESP;
            end
            OP_QUERY: state_next = ST_QUERY;
            default:  state_next = ST_RESP;
          endcase
        end
      end

      ST_ALLOC: begin
        run_ctl.clear = 1'b1;
        scan_ptr_next = END_W'(win_first);
        pend_next     = 1'b0;
        state_next    = (need_r == '0) ? ST_RESP : ST_SCAN;
      end

      ST_SCAN: begin
        // Issue the next read while the previous mark is evaluated
        ram_raddr = AW'(scan_ptr);
        if (scan_ptr < end_eff) begin
          scan_ptr_next = END_W'(scan_ptr + 1'b1);
          eval_ptr_next = scan_ptr;
          pend_next     = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        run_ctl.step = pend;
        if (run_hit) begin
          run_end_next = eval_ptr;
          start_next   = END_W'(eval_ptr + 1'b1 - need_r);
          wr_ptr_next  = END_W'(eval_ptr + 1'b1 - need_r);
          state_next   = ST_WRITE;
        end else if (!pend && (scan_ptr >= end_eff)) begin
          res_code_next = RC_NO_FIT;
          state_next    = ST_RESP;
        end
      end

      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(wr_ptr);
        ram_wdata = (wr_ptr == start_r) ? MARK_HEAD : MARK_USED;
        wr_ptr_next = END_W'(wr_ptr + 1'b1);
        if (wr_ptr == run_end) begin
          res_start_next = start_r[INDEX_W-1:0];
          state_next     = ST_RESP;
        end
      end

      ST_QUERY: begin
        res_mark_next = idx_ok ? ram_rdata : MARK_FREE;
        state_next    = ST_RESP;
      end

      ST_RESP: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_ptr <= '0;
      pend    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_ptr <= clr_ptr_next;
      pend    <= pend_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    op_r      <= op_next;
    need_r    <= need_next;
    idx_r     <= idx_next;
    scan_ptr  <= scan_ptr_next;
    eval_ptr  <= eval_ptr_next;
    start_r   <= start_next;
    run_end   <= run_end_next;
    wr_ptr    <= wr_ptr_next;
    res_start <= res_start_next;
    res_code  <= res_code_next;
    res_mark  <= res_mark_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, res_mark, res_code, res_start};
    end
  end

`ifndef SYNTHESIS
  // Run writes stay inside the found run
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (wr_ptr >= start_r) && (wr_ptr <= run_end))
    else $error("run write outside found run");

  // A found run ends no earlier than its length allows
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && run_hit |-> (32'(eval_ptr) + 1 >= 32'(need_r)))
    else $error("run shorter than request");

  // Leaving the scan without a hit means no fit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (state_next == ST_RESP) |=> (res_code == RC_NO_FIT))
    else $error("scan end without failure flag");

  // A pending result blocks the next load
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESP) && m_tvalid && !m_tready |=> (state == ST_RESP))
    else $error("result overwritten while waiting");

  // No input taken while a mark is being written for a run
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> !s_tready && ram_we)
    else $error("input accepted during run write");
`endif

endmodule
